/* rtl/su2_plaquette_accumulator_core_assert.svh */
// Assertion macros used by the checker of the plaquette accumulator.
`ifndef SU2_PLAQUETTE_ACCUMULATOR_CORE_ASSERT_SVH
`define SU2_PLAQUETTE_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define SU2PA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define SU2PA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define SU2PA_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/su2pa_pkg.sv */
`timescale 1ns / 1ps

package su2pa_pkg;

    localparam int PLAQUETTE_COUNT_BITS_DEF = 24;
    localparam int ACTION_W                 = 56;

    localparam logic [15:0] BETA_RESET     = 16'd8192;
    localparam logic [31:0] INV_NORM_RESET = 32'd0;

    localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
    localparam logic signed [15:0] Q15_MIN = 16'sh8000;

    localparam logic REG_BETA     = 1'b0;
    localparam logic REG_INV_NORM = 1'b1;

    localparam logic [1:0] CORNER_MU     = 2'd0;
    localparam logic [1:0] CORNER_NU     = 2'd1;
    localparam logic [1:0] CORNER_MU_DAG = 2'd2;
    localparam logic [1:0] CORNER_NU_DAG = 2'd3;

    typedef struct packed {
        logic signed [15:0] im12;
        logic signed [15:0] re12;
        logic signed [15:0] im11;
        logic signed [15:0] re11;
    } link_t;

    // Round a Q5.30 sum half up to Q1.15 and saturate.
    function automatic logic signed [15:0] round_q15(input logic signed [34:0] q30);
        logic [35:0]        biased;
        logic signed [20:0] shifted;
        biased  = {q30[34], q30} + 36'd16384;
        shifted = biased[35:15];
        if (shifted > 21'sd32767) begin
            return Q15_MAX;
        end else if (shifted < -21'sd32768) begin
            return Q15_MIN;
        end else begin
            return shifted[15:0];
        end
    endfunction

endpackage

/* rtl/su2_plaquette_accumulator_core.sv */
`timescale 1ns / 1ps
// SU(2) plaquette accumulator.
// Input stream (s_*): one gauge link per request, four per plaquette; tdata carries
// the two Q1.15 complex elements, tuser the corner and the time flag, tlast marks
// the last link of the run. The block keeps a running 2x2 product, adds the real
// part of its top-left element to a space or a time sum after corner 3, and on
// tlast emits one result (m_*): both averages scaled by inverse_norm and the
// action -beta times the total, then clears the sums.
// Throughput: one link per cycle while s_tready is high; the link-by-product
// multiply and its rounding sit in a single register stage, since each product
// feeds the next link. A final link passes the stages A to F in turn and F holds
// the result; links without tlast produce nothing.
// A stalled m_tready holds the result; the stages behind it keep filling until
// each holds a request, then s_tready falls. Non-final links still pass the sum
// stage while a result waits.
// Reset (aresetn low, synchronous) empties the pipeline, sets the product to the
// identity, clears both sums and loads beta = 8192, inverse_norm = 0.
// Configuration: APB, beta at 0x0, inverse_norm at 0x4; pready is always high.
module su2_plaquette_accumulator_core
    import su2pa_pkg::*;
#(
    parameter int PLAQUETTE_COUNT_BITS = PLAQUETTE_COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // u11_real, u11_imag, u12_real, u12_imag
    input  logic [2:0]  s_tuser,   // corner[1:0], time_like
    input  logic        s_tlast,   // final_link
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // space_average, time_average, action
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SUM_W   = 16 + PLAQUETTE_COUNT_BITS;
    localparam int TOT_W   = SUM_W + 1;
    localparam int MAG_W   = (SUM_W > 32) ? SUM_W : 33;
    localparam int TPAD_W  = (TOT_W > 32) ? TOT_W : 33;
    localparam int R_W     = MAG_W + 1;
    localparam int P_W     = TPAD_W + 16;
    localparam int CMP_W   = (P_W > 57) ? P_W : 57;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CMP_W-1:0] ACT_LIM = CMP_W'(1) << (ACTION_W - 1);
    localparam logic [ACTION_W-1:0] ACT_MAX = {1'b0, {(ACTION_W-1){1'b1}}};
    localparam logic [ACTION_W-1:0] ACT_MIN = {1'b1, {(ACTION_W-1){1'b0}}};

    localparam link_t IDENTITY = '{re11: Q15_MAX, im11: 16'sd0, re12: 16'sd0, im12: 16'sd0};

    // configuration
    logic [15:0] beta_reg;
    logic [31:0] inv_norm_reg;

    // pipeline registers
    logic        a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg;
    link_t       a_link_reg;
    logic [1:0]  a_corner_reg;
    logic        a_time_reg, a_final_reg;
    link_t       prod_reg;
    logic        b_last_reg, b_time_reg, b_final_reg;
    logic signed [SUM_W-1:0] space_reg, time_reg;
    logic signed [SUM_W-1:0] c_space_reg, c_time_reg;
    logic [MAG_W-1:0]  d_mag_s_reg, d_mag_t_reg;
    logic [TPAD_W-1:0] d_mag_tot_reg;
    logic              d_neg_s_reg, d_neg_t_reg, d_neg_tot_reg;
    logic [63:0]       e_s_lo_reg, e_t_lo_reg;
    logic [MAG_W-1:0]  e_s_hi_reg, e_t_hi_reg;
    logic [47:0]       e_a_lo_reg;
    logic [TPAD_W-17:0] e_a_hi_reg;
    logic              e_neg_s_reg, e_neg_t_reg, e_neg_tot_reg;
    logic [87:0]       f_data_reg;

    // flow control
    logic f_rdy, e_rdy, d_rdy, c_rdy, b_rdy, a_rdy;
    logic a_go, b_go, c_go, d_go, e_go, s_take;

    assign f_rdy  = !f_v_reg || m_tready;
    assign e_rdy  = !e_v_reg || f_rdy;
    assign d_rdy  = !d_v_reg || e_rdy;
    assign c_rdy  = !c_v_reg || d_rdy;
    assign b_rdy  = !b_v_reg || !b_final_reg || c_rdy;
    assign a_rdy  = !a_v_reg || b_rdy;
    assign a_go   = a_v_reg && b_rdy;
    assign b_go   = b_v_reg && b_rdy;
    assign c_go   = c_v_reg && d_rdy;
    assign d_go   = d_v_reg && e_rdy;
    assign e_go   = e_v_reg && f_rdy;
    assign s_take = s_tvalid && a_rdy;

    assign s_tready = a_rdy;
    assign m_tvalid = f_v_reg;
    assign m_tdata  = f_data_reg;
    assign pready   = 1'b1;

    // configuration port
    always_comb begin
        unique case (paddr[2])
            REG_BETA:     prdata = {16'd0, beta_reg};
            REG_INV_NORM: prdata = inv_norm_reg;
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg     <= BETA_RESET;
            inv_norm_reg <= INV_NORM_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_BETA:     beta_reg     <= pwdata[15:0];
                REG_INV_NORM: inv_norm_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    // link multiply
    logic signed [16:0] ur, ui, vr, vi;
    logic signed [32:0] p_ar_ur, p_ai_ui, p_br_vr, p_bi_vi;
    logic signed [32:0] p_ar_ui, p_ai_ur, p_bi_vr, p_br_vi;
    logic signed [32:0] p_ar_vr, p_ai_vi, p_br_ur, p_bi_ui;
    logic signed [32:0] p_ar_vi, p_ai_vr, p_bi_ur, p_br_ui;
    logic signed [34:0] nar, nai, nbr, nbi;
    link_t              prod_next;

    always_comb begin
        ur = 17'(a_link_reg.re11);
        ui = 17'(a_link_reg.im11);
        vr = 17'(a_link_reg.re12);
        vi = 17'(a_link_reg.im12);
        if (a_corner_reg inside {CORNER_MU_DAG, CORNER_NU_DAG}) begin
            ui = -ui;
            vr = -vr;
            vi = -vi;
        end
    end

    assign p_ar_ur = prod_reg.re11 * ur;
    assign p_ai_ui = prod_reg.im11 * ui;
    assign p_br_vr = prod_reg.re12 * vr;
    assign p_bi_vi = prod_reg.im12 * vi;
    assign p_ar_ui = prod_reg.re11 * ui;
    assign p_ai_ur = prod_reg.im11 * ur;
    assign p_bi_vr = prod_reg.im12 * vr;
    assign p_br_vi = prod_reg.re12 * vi;
    assign p_ar_vr = prod_reg.re11 * vr;
    assign p_ai_vi = prod_reg.im11 * vi;
    assign p_br_ur = prod_reg.re12 * ur;
    assign p_bi_ui = prod_reg.im12 * ui;
    assign p_ar_vi = prod_reg.re11 * vi;
    assign p_ai_vr = prod_reg.im11 * vr;
    assign p_bi_ur = prod_reg.im12 * ur;
    assign p_br_ui = prod_reg.re12 * ui;

    assign nar = 35'(p_ar_ur) - 35'(p_ai_ui) - 35'(p_br_vr) - 35'(p_bi_vi);
    assign nai = 35'(p_ar_ui) + 35'(p_ai_ur) - 35'(p_bi_vr) + 35'(p_br_vi);
    assign nbr = 35'(p_ar_vr) - 35'(p_ai_vi) + 35'(p_br_ur) + 35'(p_bi_ui);
    assign nbi = 35'(p_ar_vi) + 35'(p_ai_vr) + 35'(p_bi_ur) - 35'(p_br_ui);

    always_comb begin
        if (a_corner_reg == CORNER_MU) begin
            prod_next.re11 = ur[15:0];
            prod_next.im11 = ui[15:0];
            prod_next.re12 = vr[15:0];
            prod_next.im12 = vi[15:0];
        end else begin
            prod_next.re11 = round_q15(nar);
            prod_next.im11 = round_q15(nai);
            prod_next.re12 = round_q15(nbr);
            prod_next.im12 = round_q15(nbi);
        end
    end

    // sum update; the product register holds the top-left element of the request in B
    logic signed [SUM_W:0]   space_wide, time_wide;
    logic signed [SUM_W-1:0] space_add, time_add, space_upd, time_upd;

    assign space_wide = (SUM_W+1)'(space_reg) + (SUM_W+1)'(prod_reg.re11);
    assign time_wide  = (SUM_W+1)'(time_reg) + (SUM_W+1)'(prod_reg.re11);

    always_comb begin
        if (space_wide[SUM_W] != space_wide[SUM_W-1]) begin
            space_add = space_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            space_add = space_wide[SUM_W-1:0];
        end
        if (time_wide[SUM_W] != time_wide[SUM_W-1]) begin
            time_add = time_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            time_add = time_wide[SUM_W-1:0];
        end
        space_upd = (b_last_reg && !b_time_reg) ? space_add : space_reg;
        time_upd  = (b_last_reg && b_time_reg) ? time_add : time_reg;
    end

    // magnitudes
    logic signed [TOT_W-1:0] total;
    logic [SUM_W-1:0]        mag_s, mag_t;
    logic [TOT_W-1:0]        mag_tot;

    assign total   = TOT_W'(c_space_reg) + TOT_W'(c_time_reg);
    assign mag_s   = c_space_reg[SUM_W-1] ? -c_space_reg : c_space_reg;
    assign mag_t   = c_time_reg[SUM_W-1] ? -c_time_reg : c_time_reg;
    assign mag_tot = total[TOT_W-1] ? -total : total;

    // final scaling and saturation
    function automatic logic [15:0] avg_sat(input logic [R_W-1:0] r, input logic neg);
        logic [R_W-1:0] r_neg;
        r_neg = -r;
        if (neg) begin
            return (r > R_W'(32768)) ? Q15_MIN : r_neg[15:0];
        end else begin
            return (r > R_W'(32767)) ? Q15_MAX : r[15:0];
        end
    endfunction

    logic [64:0]       s_lo_rnd, t_lo_rnd;
    logic [R_W-1:0]    s_r, t_r;
    logic [CMP_W-1:0]  act_p, act_p_neg;
    logic [ACTION_W-1:0] act;

    assign s_lo_rnd  = {1'b0, e_s_lo_reg} + 65'h0_8000_0000;
    assign t_lo_rnd  = {1'b0, e_t_lo_reg} + 65'h0_8000_0000;
    assign s_r       = R_W'(e_s_hi_reg) + R_W'(s_lo_rnd[64:32]);
    assign t_r       = R_W'(e_t_hi_reg) + R_W'(t_lo_rnd[64:32]);
    assign act_p     = (CMP_W'(e_a_hi_reg) << 32) + CMP_W'(e_a_lo_reg);
    assign act_p_neg = -act_p;

    always_comb begin
        if (!e_neg_tot_reg) begin
            act = (act_p > ACT_LIM) ? ACT_MIN : act_p_neg[ACTION_W-1:0];
        end else begin
            act = (act_p > (ACT_LIM - CMP_W'(1))) ? ACT_MAX : act_p[ACTION_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
            e_v_reg   <= 1'b0;
            f_v_reg   <= 1'b0;
            prod_reg  <= IDENTITY;
            space_reg <= '0;
            time_reg  <= '0;
        end else begin
            a_v_reg <= s_take ? 1'b1 : (a_go ? 1'b0 : a_v_reg);
            b_v_reg <= a_go ? 1'b1 : (b_go ? 1'b0 : b_v_reg);
            c_v_reg <= (b_go && b_final_reg) ? 1'b1 : (c_go ? 1'b0 : c_v_reg);
            d_v_reg <= c_go ? 1'b1 : (d_go ? 1'b0 : d_v_reg);
            e_v_reg <= d_go ? 1'b1 : (e_go ? 1'b0 : e_v_reg);
            f_v_reg <= e_go ? 1'b1 : (m_tready ? 1'b0 : f_v_reg);
            if (a_go) begin
                prod_reg <= prod_next;
            end
            if (b_go) begin
                space_reg <= b_final_reg ? '0 : space_upd;
                time_reg  <= b_final_reg ? '0 : time_upd;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            a_link_reg   <= s_tdata;
            a_corner_reg <= s_tuser[1:0];
            a_time_reg   <= s_tuser[2];
            a_final_reg  <= s_tlast;
        end
        if (a_go) begin
            b_last_reg  <= (a_corner_reg == CORNER_NU_DAG);
            b_time_reg  <= a_time_reg;
            b_final_reg <= a_final_reg;
        end
        if (b_go && b_final_reg) begin
            c_space_reg <= space_upd;
            c_time_reg  <= time_upd;
        end
        if (c_go) begin
            d_mag_s_reg   <= MAG_W'(mag_s);
            d_mag_t_reg   <= MAG_W'(mag_t);
            d_mag_tot_reg <= TPAD_W'(mag_tot);
            d_neg_s_reg   <= c_space_reg[SUM_W-1];
            d_neg_t_reg   <= c_time_reg[SUM_W-1];
            d_neg_tot_reg <= total[TOT_W-1];
        end
        if (d_go) begin
            e_s_lo_reg    <= d_mag_s_reg[31:0] * inv_norm_reg;
            e_t_lo_reg    <= d_mag_t_reg[31:0] * inv_norm_reg;
            e_s_hi_reg    <= d_mag_s_reg[MAG_W-1:32] * inv_norm_reg;
            e_t_hi_reg    <= d_mag_t_reg[MAG_W-1:32] * inv_norm_reg;
            e_a_lo_reg    <= d_mag_tot_reg[31:0] * beta_reg;
            e_a_hi_reg    <= d_mag_tot_reg[TPAD_W-1:32] * beta_reg;
            e_neg_s_reg   <= d_neg_s_reg;
            e_neg_t_reg   <= d_neg_t_reg;
            e_neg_tot_reg <= d_neg_tot_reg;
        end
        if (e_go) begin
            f_data_reg <= {act, avg_sat(t_r, e_neg_t_reg), avg_sat(s_r, e_neg_s_reg)};
        end
    end

endmodule

/* rtl/su2pa_checker.sv */
`timescale 1ns / 1ps
`include "su2_plaquette_accumulator_core_assert.svh"

module su2pa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    logic        m_stall;
    logic        m_free;
    logic        wr_beta;
    logic [31:0] beta_wd;

    assign m_stall = m_tvalid && !m_tready;
    assign m_free  = !m_tvalid || m_tready;
    assign wr_beta = psel && penable && pwrite && pready && !paddr[2];
    assign beta_wd = {16'd0, pwdata[15:0]};

    `SU2PA_ASSERT_NEXT_ALWAYS(a_reset_empties, !aresetn, !m_tvalid, "result valid after reset")

    `SU2PA_ASSERT_NEXT(a_result_holds, m_stall, m_tvalid && $stable(m_tdata), "result not held")

    `SU2PA_ASSERT_IMPLY(a_free_output_takes, m_free, s_tready, "request refused with free output")

    `SU2PA_ASSERT_NEXT(a_beta_readback, wr_beta, paddr[2] || prdata == $past(beta_wd), "beta readback")

endmodule

bind su2_plaquette_accumulator_core su2pa_checker u_su2pa_checker (.*);

/* dv/su2_plaquette_accumulator_core_test.sv */
`timescale 1ns / 1ps

module su2_plaquette_accumulator_core_test;
    import su2pa_pkg::*;

    localparam int     SUM_W   = 16 + PLAQUETTE_COUNT_BITS_DEF;
    localparam longint SUM_MAX = (64'sd1 <<< (SUM_W - 1)) - 1;
    localparam int     N_ROWS  = 19;

    typedef struct packed {
        link_t      link;
        logic [1:0] corner;
        logic       time_like;
        logic       final_link;
    } link_req_t;

    typedef struct packed {
        logic signed [15:0]       space_average;
        logic signed [15:0]       time_average;
        logic signed [ACTION_W-1:0] action;
    } measurement_t;

    typedef struct packed {
        logic signed [15:0]       re11;
        logic signed [15:0]       im11;
        logic signed [15:0]       re12;
        logic signed [15:0]       im12;
        logic [1:0]               corner;
        logic                     time_like;
        logic                     final_link;
        logic                     typed;
        logic signed [15:0]       want_space;
        logic signed [15:0]       want_time;
        logic signed [ACTION_W-1:0] want_action;
    } directed_row_t;

    localparam directed_row_t DIRECTED [N_ROWS] = '{
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, CORNER_NU, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0, 56'sd0},
        '{Q15_MAX, 16'sd0, 16'sd0, 16'sd0, CORNER_MU, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 56'sd0},
        '{Q15_MAX, 16'sd0, 16'sd0, 16'sd0, CORNER_NU, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 56'sd0},
        '{Q15_MAX, 16'sd0, 16'sd0, 16'sd0, CORNER_MU_DAG, 1'b0, 1'b0, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{Q15_MAX, 16'sd0, 16'sd0, 16'sd0, CORNER_NU_DAG, 1'b0, 1'b1, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{Q15_MIN, Q15_MIN, Q15_MIN, Q15_MIN, CORNER_MU, 1'b1, 1'b0, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{Q15_MAX, Q15_MAX, Q15_MAX, Q15_MAX, CORNER_NU, 1'b1, 1'b0, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{Q15_MIN, Q15_MIN, Q15_MIN, Q15_MIN, CORNER_MU_DAG, 1'b1, 1'b0, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{Q15_MAX, Q15_MAX, Q15_MAX, Q15_MAX, CORNER_NU_DAG, 1'b1, 1'b0, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{16'sd23170, 16'sd23170, 16'sd0, 16'sd0, CORNER_NU_DAG, 1'b1, 1'b0, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{16'sd0, 16'sd23170, 16'sd23170, 16'sd0, CORNER_MU_DAG, 1'b0, 1'b0, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384, CORNER_NU, 1'b0, 1'b0, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{16'sd0, 16'sd0, 16'sd0, Q15_MAX, CORNER_NU_DAG, 1'b0, 1'b1, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{16'sd1000, 16'sd2000, 16'sd3000, 16'sd4000, CORNER_MU, 1'b0, 1'b0, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{-16'sd5, 16'sd7, -16'sd9, 16'sd11, CORNER_MU, 1'b0, 1'b1, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, CORNER_NU, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0, 56'sd0},
        '{Q15_MAX, Q15_MIN, Q15_MAX, Q15_MIN, CORNER_NU_DAG, 1'b0, 1'b0, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, CORNER_NU_DAG, 1'b1, 1'b0, 1'b0,
          16'sd0, 16'sd0, 56'sd0},
        '{16'sd1, 16'sd1, 16'sd1, 16'sd1, CORNER_NU_DAG, 1'b0, 1'b1, 1'b0,
          16'sd0, 16'sd0, 56'sd0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    longint      link_prod [4];
    longint      space_acc;
    longint      time_acc;
    logic [15:0] beta_reg;
    logic [31:0] inv_norm_reg;

    measurement_t awaited_measurements [$];
    int           mismatches     = 0;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    int           sink_hold      = 0;

    su2_plaquette_accumulator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint q15_round(input longint q30);
        longint s;
        s = (q30 + 64'sd16384) >>> 15;
        if (s > 32767) begin
            s = 32767;
        end else if (s < -32768) begin
            s = -32768;
        end
        return s;
    endfunction

    function automatic longint clamp_sum(input longint s);
        if (s > SUM_MAX) begin
            return SUM_MAX;
        end else if (s < -SUM_MAX - 1) begin
            return -SUM_MAX - 1;
        end
        return s;
    endfunction

    function automatic logic signed [15:0] scaled_mean(input longint s);
        bit [63:0] mag;
        bit [63:0] r;
        bit [63:0] inv;
        inv = {32'd0, inv_norm_reg};
        mag = (s < 0) ? 64'(-s) : 64'(s);
        r = (mag >> 32) * inv + (((mag & 64'hFFFF_FFFF) * inv + 64'h8000_0000) >> 32);
        if (s < 0) begin
            return (r > 64'd32768) ? Q15_MIN : 16'(-longint'(r));
        end
        return (r > 64'd32767) ? Q15_MAX : 16'(r);
    endfunction

    function automatic void reset_model();
        link_prod[0] = 32767;
        link_prod[1] = 0;
        link_prod[2] = 0;
        link_prod[3] = 0;
        space_acc    = 0;
        time_acc     = 0;
        beta_reg     = BETA_RESET;
        inv_norm_reg = INV_NORM_RESET;
    endfunction

    function automatic bit measure_link(input link_req_t r, output measurement_t m);
        longint    ur, ui, vr, vi, ar, ai, br, bi, total, act;
        bit [63:0] mag, scaled, lim;
        ur = longint'(r.link.re11);
        ui = longint'(r.link.im11);
        vr = longint'(r.link.re12);
        vi = longint'(r.link.im12);
        m  = '0;
        if (r.corner >= CORNER_MU_DAG) begin
            ui = -ui;
            vr = -vr;
            vi = -vi;
        end
        if (r.corner == CORNER_MU) begin
            link_prod[0] = ur;
            link_prod[1] = ui;
            link_prod[2] = vr;
            link_prod[3] = vi;
        end else begin
            ar = link_prod[0];
            ai = link_prod[1];
            br = link_prod[2];
            bi = link_prod[3];
            link_prod[0] = q15_round((ar * ur - ai * ui) - (br * vr + bi * vi));
            link_prod[1] = q15_round((ar * ui + ai * ur) - (bi * vr - br * vi));
            link_prod[2] = q15_round((ar * vr - ai * vi) + (br * ur + bi * ui));
            link_prod[3] = q15_round((ar * vi + ai * vr) + (bi * ur - br * ui));
        end
        if (r.corner == CORNER_NU_DAG) begin
            if (r.time_like) begin
                time_acc = clamp_sum(time_acc + link_prod[0]);
            end else begin
                space_acc = clamp_sum(space_acc + link_prod[0]);
            end
        end
        if (!r.final_link) begin
            return 1'b0;
        end
        total  = space_acc + time_acc;
        mag    = (total < 0) ? 64'(-total) : 64'(total);
        scaled = mag * {48'd0, beta_reg};
        lim    = 64'd1 << (ACTION_W - 1);
        if (total >= 0) begin
            act = (scaled > lim) ? -longint'(lim) : -longint'(scaled);
        end else begin
            act = (scaled > lim - 1) ? longint'(lim - 1) : longint'(scaled);
        end
        m.space_average = scaled_mean(space_acc);
        m.time_average  = scaled_mean(time_acc);
        m.action        = act[ACTION_W-1:0];
        space_acc = 0;
        time_acc  = 0;
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] pick_word(input int mode);
        case (mode)
            0: begin
                return 16'($urandom);
            end
            1: begin
                return 16'(int'($urandom_range(16383)) - 8192);
            end
            default: begin
                case ($urandom_range(4))
                    0: return Q15_MIN;
                    1: return -16'sd1;
                    2: return 16'sd0;
                    3: return 16'sd1;
                    default: return Q15_MAX;
                endcase
            end
        endcase
    endfunction

    function automatic link_t pick_link();
        link_t l;
        int    mode;
        mode   = $urandom_range(2);
        l.re11 = (mode == 1) ? 16'(20000 + $urandom_range(12767)) : pick_word(mode);
        l.im11 = pick_word(mode);
        l.re12 = pick_word(mode);
        l.im12 = pick_word(mode);
        return l;
    endfunction

    // Hold the request until taken, then predict.
    task automatic offer_link(input link_req_t r, input bit use_typed, input measurement_t typed_m);
        measurement_t m;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.link;
        s_tuser  <= {r.time_like, r.corner};
        s_tlast  <= r.final_link;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        if (measure_link(r, m)) begin
            awaited_measurements.push_back(use_typed ? typed_m : m);
        end
        @(negedge aclk);
    endtask

    task automatic send_plaquettes(input int count, input int len, input bit close_run);
        link_req_t r;
        for (int p = 0; p < count; p++) begin
            r.time_like = $urandom_range(1);
            for (int c = 0; c < len; c++) begin
                r.link       = pick_link();
                r.corner     = 2'(c);
                r.final_link = close_run && (p == count - 1) && (c == len - 1);
                offer_link(r, 1'b0, '0);
            end
        end
    endtask

    task automatic send_random(input int budget);
        link_req_t r;
        int        sent;
        int        pick;
        int        n;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                n = $urandom_range(1, 6);
                send_plaquettes(n, 4, 1'b1);
                sent += 4 * n;
            end else if (pick < 88) begin
                n = $urandom_range(1, 3);
                send_plaquettes(n, $urandom_range(1, 3), 1'b1);
                sent += 2 * n;
            end else begin
                r.link       = pick_link();
                r.corner     = 2'($urandom_range(3));
                r.time_like  = $urandom_range(1);
                r.final_link = ($urandom_range(4) == 0);
                offer_link(r, 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        if (addr == {REG_BETA, 2'b00}) begin
            beta_reg = value[15:0];
        end else begin
            inv_norm_reg = value;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Drain every awaited result, then let trailing links leave the pipeline.
    task automatic drain_block();
        while (awaited_measurements.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        measurement_t want;
        measurement_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.space_average = m_tdata[15:0];
            got.time_average  = m_tdata[31:16];
            got.action        = m_tdata[32 +: ACTION_W];
            if (awaited_measurements.size() == 0) begin
                $error("unexpected result: space_average %0d time_average %0d action %0d",
                       got.space_average, got.time_average, got.action);
                mismatches++;
            end else begin
                want = awaited_measurements.pop_front();
                if (got.space_average !== want.space_average) begin
                    $error("space_average: expected %0d, actual %0d",
                           want.space_average, got.space_average);
                    mismatches++;
                end
                if (got.time_average !== want.time_average) begin
                    $error("time_average: expected %0d, actual %0d",
                           want.time_average, got.time_average);
                    mismatches++;
                end
                if (got.action !== want.action) begin
                    $error("action: expected %0d, actual %0d", want.action, got.action);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("su2_plaquette_accumulator_core_test: FAIL");
        $finish;
    end

    initial begin
        link_req_t    r;
        measurement_t typed_m;
        reset_model();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_ROWS; i++) begin
            r.link.re11          = DIRECTED[i].re11;
            r.link.im11          = DIRECTED[i].im11;
            r.link.re12          = DIRECTED[i].re12;
            r.link.im12          = DIRECTED[i].im12;
            r.corner             = DIRECTED[i].corner;
            r.time_like          = DIRECTED[i].time_like;
            r.final_link         = DIRECTED[i].final_link;
            typed_m.space_average = DIRECTED[i].want_space;
            typed_m.time_average  = DIRECTED[i].want_time;
            typed_m.action        = DIRECTED[i].want_action;
            offer_link(r, DIRECTED[i].typed, typed_m);
        end
        s_tvalid <= 1'b0;
        drain_block();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    apb_write({REG_BETA, 2'b00}, 32'd0);
                    apb_write({REG_INV_NORM, 2'b00}, 32'hFFFF_FFFF);
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    apb_write({REG_BETA, 2'b00}, 32'd65535);
                    apb_write({REG_INV_NORM, 2'b00}, 32'd0);
                    src_idle_pct   = 53;
                    sink_stall_pct = 0;
                end
                2: begin
                    apb_write({REG_BETA, 2'b00}, 32'(BETA_RESET));
                    apb_write({REG_INV_NORM, 2'b00}, 32'($urandom_range(1 << 24)));
                    src_idle_pct   = 0;
                    sink_stall_pct = 53;
                end
                3: begin
                    apb_write({REG_BETA, 2'b00}, 32'($urandom_range(65535)));
                    apb_write({REG_INV_NORM, 2'b00}, $urandom);
                    src_idle_pct   = 6;
                    sink_stall_pct = 6;
                end
                default: begin
                    apb_write({REG_BETA, 2'b00}, 32'd65535);
                    apb_write({REG_INV_NORM, 2'b00}, 32'hFFFF_FFFF);
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            if (phase == 2) begin
                // Block the result side while plaquettes keep arriving.
                sink_hold = 400;
                send_plaquettes(1, 4, 1'b1);
                for (int k = 0; k < 11; k++) begin
                    send_plaquettes(1, 4, 1'b1);
                end
            end
            send_random(75);
            if (phase == 4) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (awaited_measurements.size() != 0) begin
                    @(negedge aclk);
                end
            end
            send_random(75);
            s_tvalid <= 1'b0;
            drain_block();
        end

        if (mismatches == 0 && awaited_measurements.size() == 0) begin
            $display("su2_plaquette_accumulator_core_test: PASS");
        end else begin
            $display("su2_plaquette_accumulator_core_test: FAIL");
        end
        $finish;
    end

endmodule
